@@ sv/lazy_xor_segment_tree_pair_xor_sum_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the pair-XOR range block
// Short helper macros that wrap a labeled concurrent assertion.
// ----------------------------------------------------------------------------
`ifndef LAZY_XOR_SEGMENT_TREE_PAIR_XOR_SUM_MACROS_SVH
`define LAZY_XOR_SEGMENT_TREE_PAIR_XOR_SUM_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define LXS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define LXS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ sv/lxs_pkg.sv @@
// ----------------------------------------------------------------------------
// Pair-XOR range block package
// Shared widths and command codes.
// ----------------------------------------------------------------------------
`default_nettype none
package lxs_pkg;
	localparam int Entries = 1024;
	localparam int Bits    = 20;
	localparam int IdxW    = 10;
	localparam int CntW    = 11;
	localparam int SumW    = 38;

	typedef enum logic [1:0] {
		CMD_LOAD   = 2'd0,
		CMD_UPDATE = 2'd1,
		CMD_QUERY  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;
endpackage
`default_nettype wire

@@ sv/lxs_if.sv @@
// ----------------------------------------------------------------------------
// Valid/ready channel interfaces
// Input command channel and result channel.
// ----------------------------------------------------------------------------
`default_nettype none
interface lxs_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [9:0]  first_index;
	logic [9:0]  last_index;
	logic        parity;
	logic [19:0] value;
	modport source (output valid, cmd, first_index, last_index, parity, value, input ready);
	modport sink (input valid, cmd, first_index, last_index, parity, value, output ready);
endinterface

interface lxs_out_if;
	logic        valid;
	logic        ready;
	logic [37:0] pair_xor_sum;
	modport source (output valid, pair_xor_sum, input ready);
	modport sink (input valid, pair_xor_sum, output ready);
endinterface
`default_nettype wire

@@ sv/lxs_mac.sv @@
// ----------------------------------------------------------------------------
// Pair-XOR accumulator
// Adds 2^bit * zeros * ones for one bit per cycle while enabled.
// ----------------------------------------------------------------------------
`default_nettype none
module lxs_mac (
	input  wire logic                     clk,
	input  wire logic                     clr,
	input  wire logic                     en,
	input  wire logic [4:0]               bit_idx,
	input  wire logic [lxs_pkg::CntW-1:0] ones,
	input  wire logic [lxs_pkg::CntW-1:0] total,
	output logic [lxs_pkg::SumW-1:0]      sum
);
	import lxs_pkg::*;
	logic [CntW-1:0]   zeros;
	logic [2*CntW-1:0] prod;
	logic [SumW-1:0]   sum_q;

	assign zeros = total - ones;
	assign prod  = zeros * ones;
	assign sum   = sum_q;

	always_ff @(posedge clk) begin
		if (clr) begin
			sum_q <= '0;
		end else if (en) begin
			sum_q <= sum_q + (SumW'(prod) << bit_idx);
		end
	end
endmodule
`default_nettype wire

@@ sv/lazy_xor_segment_tree_pair_xor_sum.sv @@
// ----------------------------------------------------------------------------
// Range pair-XOR sum engine
// Keeps 1024 entries of a 20-bit value and a class; supports load, masked
// class update over a range, and pair-XOR sum queries over a range.
// ----------------------------------------------------------------------------
// One transaction is taken at a time and ready stays low while it runs. The
// entries live in a memory with one write port and one registered read port
// that one scan sequencer visits one entry at a time (a read state, then a
// write or count state). A load passes through the accept cycle and the
// write. An update or a query over a range passes through the accept cycle,
// then the read and the write state of each index. An update with a
// zero mask or an empty range ends in its accept cycle. A query then steps
// through the multiply-accumulate unit one value bit at a time, and its
// result waits in an output register until the receiver takes it. After
// reset the block first clears all 1024 memory entries, with ready low.
// ----------------------------------------------------------------------------
`default_nettype none
`include "lazy_xor_segment_tree_pair_xor_sum_macros.svh"
module lazy_xor_segment_tree_pair_xor_sum (
	input  wire logic clk,
	input  wire logic arst_n,
	lxs_in_if.sink    in_ch,
	lxs_out_if.source out_ch
);
	import lxs_pkg::*;

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_RD    = 6'b000100,
		ST_WR    = 6'b001000,
		ST_MAC   = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	state_t state_q;
	// Entry word: present, class, value.
	logic [Bits+1:0]  mem [Entries];
	logic [Bits+1:0]  rd_q;
	logic [IdxW-1:0]  idx_q, last_q;
	logic [1:0]       cmd_q;
	logic             par_q, rd_ok_q;
	logic [Bits-1:0]  val_q;
	logic [CntW-1:0]  ones_q [Bits];
	logic [CntW-1:0]  total_q;
	logic [4:0]       bit_q;
	logic [SumW-1:0]  sum;
	logic             mac_clr, mac_en;
	logic             wr_en;
	logic [IdxW-1:0]  wr_addr;
	logic [Bits+1:0]  wr_data;

	assign in_ch.ready         = (state_q == ST_IDLE);
	assign out_ch.valid        = (state_q == ST_OUT);
	assign out_ch.pair_xor_sum = sum;
	assign mac_clr = in_ch.valid && in_ch.ready;
	assign mac_en  = (state_q == ST_MAC);

	lxs_mac u_mac (
		.clk(clk), .clr(mac_clr), .en(mac_en), .bit_idx(bit_q),
		.ones(ones_q[bit_q]), .total(total_q), .sum(sum)
	);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = rd_q;
		if (state_q == ST_CLEAR) begin
			wr_en   = 1'b1;
			wr_data = '0;
		end else if (state_q == ST_WR && cmd_q == CMD_LOAD) begin
			wr_en   = 1'b1;
			wr_data = {1'b1, par_q, val_q};
		end else if (state_q == ST_WR && cmd_q == CMD_UPDATE && rd_ok_q) begin
			wr_en = rd_q[Bits+1] && (rd_q[Bits] == par_q);
			wr_data = {rd_q[Bits+1:Bits], rd_q[Bits-1:0] ^ val_q};
		end
	end

	// Memory: at most one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			idx_q   <= '0;
			rd_ok_q <= 1'b0;
			bit_q   <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == IdxW'(Entries - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					rd_ok_q <= 1'b0;
					bit_q   <= '0;
					if (in_ch.valid) begin
						idx_q <= in_ch.first_index;
						case (cmd_t'(in_ch.cmd))
							CMD_LOAD:   state_q <= ST_WR;
							CMD_UPDATE: state_q <= (in_ch.value != '0 &&
								in_ch.first_index <= in_ch.last_index) ? ST_RD : ST_IDLE;
							CMD_QUERY:  state_q <= (in_ch.first_index <= in_ch.last_index)
								? ST_RD : ST_MAC;
							default:    state_q <= ST_IDLE;
						endcase
					end
				end
				ST_RD: begin
					// Memory output for idx_q is valid next cycle.
					rd_ok_q <= 1'b1;
					state_q <= ST_WR;
				end
				ST_WR: begin
					rd_ok_q <= 1'b0;
					if (cmd_q == CMD_LOAD) begin
						state_q <= ST_IDLE;
					end else if (idx_q == last_q) begin
						state_q <= (cmd_q == CMD_QUERY) ? ST_MAC : ST_IDLE;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_RD;
					end
				end
				ST_MAC: begin
					bit_q <= bit_q + 1'b1;
					if (bit_q == 5'(Bits - 1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_ch.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Command payload and per-bit counters for a query.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_ch.valid) begin
			cmd_q   <= in_ch.cmd;
			last_q  <= in_ch.last_index;
			par_q   <= in_ch.parity;
			val_q   <= in_ch.value;
			total_q <= '0;
			for (int b = 0; b < Bits; b++) begin
				ones_q[b] <= '0;
			end
		end else if (state_q == ST_WR && cmd_q == CMD_QUERY && rd_q[Bits+1]) begin
			total_q <= total_q + 1'b1;
			for (int b = 0; b < Bits; b++) begin
				ones_q[b] <= ones_q[b] + CntW'(rd_q[b]);
			end
		end
	end

	`LXS_ASSERT_IMP(a_ready_idle, clk, arst_n, in_ch.ready, !out_ch.valid)
	`LXS_ASSERT_NEXT(a_out_holds, clk, arst_n, out_ch.valid && !out_ch.ready, out_ch.valid)
	`LXS_ASSERT_IMP(a_ones_le_total, clk, arst_n, state_q == ST_MAC, ones_q[bit_q] <= total_q)
endmodule
`default_nettype wire
